FILE: src/cof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cof_pkg
// Shared constants and codes of the cell orientation frame block.
// ----------------------------------------------------------------------------
package cof_pkg;

	// vector magnitudes are normalized so the largest lies in [2^29, 2^30)
	localparam int NORM_BITS = 30;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_UP_X = 2'd1,
		CFG_UP_Y = 2'd2,
		CFG_UP_Z = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_POINT   = 2'd0,
		MODE_LINE    = 2'd1,
		MODE_SURFACE = 2'd2
	} cell_mode_t;

endpackage

FILE: src/cof_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cof_unit
// Pipelined vector normalizer: common normalizing shift, sum of squares,
// bit-per-stage integer square root and bit-per-stage restoring divide.
// ----------------------------------------------------------------------------
module cof_unit import cof_pkg::*; #(
	parameter int IW        = 65,
	parameter int FRAC_BITS = 16,
	parameter int SW        = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic signed [IW-1:0]        vec [3],
	input  logic [SW-1:0]               in_side,
	output logic                        out_valid,
	output logic                        zero,
	output logic signed [FRAC_BITS+1:0] unit_vec [3],
	output logic [SW-1:0]               out_side
);

	localparam int UW        = FRAC_BITS + 2;
	localparam int QW        = FRAC_BITS + 1;
	localparam int BLW       = $clog2(IW + 1);
	localparam int AW        = NORM_BITS;
	localparam int SUMW      = 2 * NORM_BITS + 2;
	localparam int SQW       = SUMW + 2;
	localparam int SQ_STEPS  = SUMW / 2 + 1;
	localparam int LW        = NORM_BITS + 1;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int CW        = 3 * AW + 4 + SW;

	// carry word: {a0, a1, a2, neg0, neg1, neg2, zero, side}
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [IW-1:0] mag_c [3];
	logic [IW-1:0] mag_s1 [3], mag_s2 [3], mag_s3 [3];
	logic          neg_s1 [3], neg_s2 [3], neg_s3 [3];
	logic [SW-1:0] side_s1, side_s2, side_s3;
	logic [IW-1:0] max_s2;
	logic [BLW-1:0] bl_c, bl_s3;
	logic          zero_s3;
	logic [AW-1:0] a_c [3];
	logic [CW-1:0] car_s4, car_s5, car_s6;
	logic [2*AW-1:0] sq_s5 [3];
	logic [SUMW-1:0] sum_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec[i][IW-1] ? (~vec[i] + 1'b1) : vec[i];
		end
	end

	// magnitudes and signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_c[i];
			neg_s1[i] <= vec[i][IW-1];
		end
		side_s1 <= in_side;
	end

	// largest magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		logic [IW-1:0] m01;
		m01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		max_s2  <= (m01 > mag_s1[2]) ? m01 : mag_s1[2];
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		side_s2 <= side_s1;
	end

	// bit length of the largest magnitude
	always_comb begin
		bl_c = '0;
		for (int k = 0; k < IW; k++) begin
			if (max_s2[k]) begin
				bl_c = BLW'(k + 1);
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		bl_s3   <= bl_c;
		zero_s3 <= (max_s2 == '0);
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;
		side_s3 <= side_s2;
	end

	// common shift
	always_comb begin
		logic [IW-1:0] sh;
		for (int i = 0; i < 3; i++) begin
			if (bl_s3 > BLW'(AW)) begin
				sh = mag_s3[i] >> (bl_s3 - BLW'(AW));
			end else begin
				sh = mag_s3[i] << (BLW'(AW) - bl_s3);
			end
			a_c[i] = sh[AW-1:0];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		car_s4 <= {a_c[0], a_c[1], a_c[2], neg_s3[0], neg_s3[1], neg_s3[2], zero_s3, side_s3};
		for (int i = 0; i < 3; i++) begin
			sq_s5[i] <= car_s4[SW+4+(2-i)*AW +: AW] * car_s4[SW+4+(2-i)*AW +: AW];
		end
		car_s5 <= car_s4;
		sum_s6 <= SUMW'(sq_s5[0]) + SUMW'(sq_s5[1]) + SUMW'(sq_s5[2]);
		car_s6 <= car_s5;
	end

	// square root, one result bit per stage
	logic          sqv_s [SQ_STEPS];
	logic [SQW-1:0] sqx_s [SQ_STEPS];
	logic [SQW-1:0] sqr_s [SQ_STEPS];
	logic [CW-1:0]  sqc_s [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SQW-1:0] BIT = SQW'(1) << (SUMW - 2 * k);
		logic           vi;
		logic [SQW-1:0] xi, ri, tr;
		logic [CW-1:0]  ci;
		if (k == 0) begin : g_first
			assign vi = v_s6;
			assign xi = SQW'(sum_s6);
			assign ri = '0;
			assign ci = car_s6;
		end else begin : g_next
			assign vi = sqv_s[k-1];
			assign xi = sqx_s[k-1];
			assign ri = sqr_s[k-1];
			assign ci = sqc_s[k-1];
		end
		assign tr = ri + BIT;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k] <= 1'b0;
			end else begin
				sqv_s[k] <= vi;
			end
		end
		always_ff @(posedge clk) begin
			if (xi >= tr) begin
				sqx_s[k] <= xi - tr;
				sqr_s[k] <= (ri >> 1) + BIT;
			end else begin
				sqx_s[k] <= xi;
				sqr_s[k] <= ri >> 1;
			end
			sqc_s[k] <= ci;
		end
	end

	// restoring divide |a| * 2^FRAC_BITS / len, one quotient bit per stage
	logic          dv_s   [DIV_STEPS];
	logic [LW-1:0] drem_s [DIV_STEPS][3];
	logic [QW-1:0] dq_s   [DIV_STEPS][3];
	logic [LW-1:0] dl_s   [DIV_STEPS];
	logic [CW-1:0] dc_s   [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic          vi;
		logic [LW-1:0] li;
		logic [CW-1:0] ci;
		logic [LW-1:0] remi [3];
		logic [QW-1:0] qi [3];
		logic          bi [3];
		if (k == 0) begin : g_first
			assign vi = sqv_s[SQ_STEPS-1];
			assign li = sqr_s[SQ_STEPS-1][LW-1:0];
			assign ci = sqc_s[SQ_STEPS-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign remi[i] = LW'(ci[SW+4+(2-i)*AW+1 +: AW-1]);
				assign bi[i]   = ci[SW+4+(2-i)*AW];
				assign qi[i]   = '0;
			end
		end else begin : g_next
			assign vi = dv_s[k-1];
			assign li = dl_s[k-1];
			assign ci = dc_s[k-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign remi[i] = drem_s[k-1][i];
				assign bi[i]   = 1'b0;
				assign qi[i]   = dq_s[k-1][i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else begin
				dv_s[k] <= vi;
			end
		end
		always_ff @(posedge clk) begin
			logic [LW:0] t;
			for (int i = 0; i < 3; i++) begin
				t = {remi[i], bi[i]};
				if (t >= {1'b0, li}) begin
					drem_s[k][i] <= LW'(t - {1'b0, li});
					dq_s[k][i]   <= {qi[i][QW-2:0], 1'b1};
				end else begin
					drem_s[k][i] <= t[LW-1:0];
					dq_s[k][i]   <= {qi[i][QW-2:0], 1'b0};
				end
			end
			dl_s[k] <= li;
			dc_s[k] <= ci;
		end
	end

	// signed result
	logic [CW-1:0]        cf;
	logic signed [UW-1:0] u_c [3];
	assign cf = dc_s[DIV_STEPS-1];
	always_comb begin
		logic signed [UW-1:0] qs;
		for (int i = 0; i < 3; i++) begin
			qs = {1'b0, dq_s[DIV_STEPS-1][i]};
			if (cf[SW]) begin
				u_c[i] = '0;
			end else begin
				u_c[i] = cf[SW+3-i] ? -qs : qs;
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= dv_s[DIV_STEPS-1];
		end
	end
	always_ff @(posedge clk) begin
		unit_vec <= u_c;
		zero     <= cf[SW];
		out_side <= cf[SW-1:0];
	end

endmodule

FILE: src/cell_orientation_frame_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_orientation_frame_top
// Orientation frame (strike, dip, normal) of one mesh cell, Q fixed point.
// ----------------------------------------------------------------------------
// Pipeline: the delay from start to done is set mostly by the two normalizers,
//   each a 32-stage square root and a FRAC_BITS+1 stage divider.
// Throughput: one transaction per cycle; busy is never raised.
// Reset: arst_n clears all valid bits and restores the registers to surface
//   mode, up = (0, 0, 1.0); results are never held off by the receiver.
// ----------------------------------------------------------------------------
module cell_orientation_frame_top import cof_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	// command side
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] jac_0,
	input  logic signed [31:0] jac_1,
	input  logic signed [31:0] jac_2,
	input  logic signed [31:0] jac_3,
	input  logic signed [31:0] jac_4,
	input  logic signed [31:0] jac_5,
	input  logic signed [31:0] jac_det,
	// result side, one-cycle strobe
	output logic               done,
	output logic signed [31:0] frame_0,
	output logic signed [31:0] frame_1,
	output logic signed [31:0] frame_2,
	output logic signed [31:0] frame_3,
	output logic signed [31:0] frame_4,
	output logic signed [31:0] frame_5,
	output logic signed [31:0] frame_6,
	output logic signed [31:0] frame_7,
	output logic signed [31:0] frame_8,
	output logic               degenerate
);

	localparam int UW   = FRAC_BITS + 2;        // unit vector component
	localparam int N1W  = 65;                   // Jacobian cross product
	localparam int PW2  = 32 + UW;              // up x r products
	localparam int IW2  = PW2 + 1;              // strike before normalizing
	localparam int QPW  = 2 * UW;               // r x p products
	localparam int QDW  = QPW + 1;
	localparam int QTW  = QDW - FRAC_BITS + 1;  // dip after rescale
	localparam int WPW  = QTW + 32;             // weighted products
	localparam int MGW  = WPW - FRAC_BITS;
	localparam int SA   = 96;                   // {j0, j1, det}
	localparam int SB   = 3 * UW + 1 + SA;      // {r, zero_a, j0, j1, det}
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	// the receiver never stalls and every stage advances each cycle
	assign busy = 1'b0;

	// ---------------- configuration registers ----------------
	logic [1:0]         mode_q;
	logic signed [31:0] up_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SURFACE;
			up_q[0] <= 32'sd0;
			up_q[1] <= 32'sd0;
			up_q[2] <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MODE: mode_q  <= cfg_data[1:0];
				CFG_UP_X: up_q[0] <= cfg_data;
				CFG_UP_Y: up_q[1] <= cfg_data;
				CFG_UP_Z: up_q[2] <= cfg_data;
				default:  mode_q  <= mode_q;
			endcase
		end
	end

	// ---------------- s1..s3: Jacobian column cross product ----------------
	logic                 v_s1, v_s2, v_s3;
	logic signed [31:0]   j_s1 [6];
	logic signed [31:0]   det_s1;
	logic signed [63:0]   pj_s2 [6];
	logic [SA-1:0]        sa_s2, sa_s3;
	logic signed [N1W-1:0] n_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		j_s1[0] <= jac_0;
		j_s1[1] <= jac_1;
		j_s1[2] <= jac_2;
		j_s1[3] <= jac_3;
		j_s1[4] <= jac_4;
		j_s1[5] <= jac_5;
		det_s1  <= jac_det;
		// columns are (j0, j2, j4) and (j1, j3, j5)
		pj_s2[0] <= j_s1[2] * j_s1[5];
		pj_s2[1] <= j_s1[4] * j_s1[3];
		pj_s2[2] <= j_s1[4] * j_s1[1];
		pj_s2[3] <= j_s1[0] * j_s1[5];
		pj_s2[4] <= j_s1[0] * j_s1[3];
		pj_s2[5] <= j_s1[2] * j_s1[1];
		sa_s2    <= {j_s1[0], j_s1[1], det_s1};
		for (int i = 0; i < 3; i++) begin
			n_s3[i] <= N1W'(pj_s2[2*i]) - N1W'(pj_s2[2*i+1]);
		end
		sa_s3 <= sa_s2;
	end

	// ---------------- normal r ----------------
	logic                 va;
	logic                 zero_a;
	logic signed [UW-1:0] r_a [3];
	logic [SA-1:0]        sa_a;

	cof_unit #(
		.IW        (N1W),
		.FRAC_BITS (FRAC_BITS),
		.SW        (SA)
	) u_norm_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.vec       (n_s3),
		.in_side   (sa_s3),
		.out_valid (va),
		.zero      (zero_a),
		.unit_vec  (r_a),
		.out_side  (sa_a)
	);

	// ---------------- s4..s5: strike = up x r ----------------
	// user must keep up stable while transactions are in flight; not enforced
	logic                 v_s4, v_s5;
	logic signed [PW2-1:0] pu_s4 [6];
	logic [SB-1:0]        sb_s4, sb_s5;
	logic signed [IW2-1:0] ps_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= va;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		pu_s4[0] <= up_q[1] * r_a[2];
		pu_s4[1] <= up_q[2] * r_a[1];
		pu_s4[2] <= up_q[2] * r_a[0];
		pu_s4[3] <= up_q[0] * r_a[2];
		pu_s4[4] <= up_q[0] * r_a[1];
		pu_s4[5] <= up_q[1] * r_a[0];
		sb_s4    <= {r_a[0], r_a[1], r_a[2], zero_a, sa_a};
		for (int i = 0; i < 3; i++) begin
			ps_s5[i] <= IW2'(pu_s4[2*i]) - IW2'(pu_s4[2*i+1]);
		end
		sb_s5 <= sb_s4;
	end

	// ---------------- strike p ----------------
	logic                 vb;
	logic                 zero_b;
	logic signed [UW-1:0] p_b [3];
	logic [SB-1:0]        sb_b;

	cof_unit #(
		.IW        (IW2),
		.FRAC_BITS (FRAC_BITS),
		.SW        (SB)
	) u_norm_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.vec       (ps_s5),
		.in_side   (sb_s5),
		.out_valid (vb),
		.zero      (zero_b),
		.unit_vec  (p_b),
		.out_side  (sb_b)
	);

	// ---------------- s6..s8: dip = r x p, rescaled ----------------
	logic                 v_s6, v_s7, v_s8, v_s9, v_s10;
	logic signed [UW-1:0] r_b [3];
	logic signed [UW-1:0] r_s6 [3], r_s7 [3], r_s8 [3];
	logic signed [UW-1:0] p_s6 [3], p_s7 [3], p_s8 [3];
	logic [SA-1:0]        sa_s6, sa_s7, sa_s8;
	logic                 dg_s6, dg_s7, dg_s8, dg_s9, dg_s10;
	logic signed [QPW-1:0] qp_s6 [6];
	logic signed [QDW-1:0] qd_s7 [3];
	logic signed [QTW-1:0] qt_s8 [3];
	logic signed [QTW-1:0] qt_c [3];

	assign r_b[0] = sb_b[SA+1+2*UW +: UW];
	assign r_b[1] = sb_b[SA+1+UW +: UW];
	assign r_b[2] = sb_b[SA+1 +: UW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s6  <= vb;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// truncate toward zero after dropping FRAC_BITS
	always_comb begin
		logic [QDW-1:0] mg;
		logic [QDW-1:0] sh;
		for (int i = 0; i < 3; i++) begin
			mg = qd_s7[i][QDW-1] ? (~qd_s7[i] + 1'b1) : qd_s7[i];
			sh = mg >> FRAC_BITS;
			qt_c[i] = qd_s7[i][QDW-1] ? -QTW'(sh) : QTW'(sh);
		end
	end

	always_ff @(posedge clk) begin
		qp_s6[0] <= r_b[1] * p_b[2];
		qp_s6[1] <= r_b[2] * p_b[1];
		qp_s6[2] <= r_b[2] * p_b[0];
		qp_s6[3] <= r_b[0] * p_b[2];
		qp_s6[4] <= r_b[0] * p_b[1];
		qp_s6[5] <= r_b[1] * p_b[0];
		r_s6  <= r_b;
		p_s6  <= p_b;
		dg_s6 <= sb_b[SA] | zero_b;
		sa_s6 <= sb_b[SA-1:0];
		for (int i = 0; i < 3; i++) begin
			qd_s7[i] <= QDW'(qp_s6[2*i]) - QDW'(qp_s6[2*i+1]);
		end
		r_s7  <= r_s6;
		p_s7  <= p_s6;
		dg_s7 <= dg_s6;
		sa_s7 <= sa_s6;
		qt_s8 <= qt_c;
		r_s8  <= r_s7;
		p_s8  <= p_s7;
		dg_s8 <= dg_s7;
		sa_s8 <= sa_s7;
	end

	// ---------------- s9..s10: weighting by the determinant ----------------
	logic signed [WPW-1:0] wp_s9 [9];
	logic signed [31:0]    j0_s9, j1_s9, j0_s10, j1_s10;
	logic [MGW-1:0]        wm_s10 [9];
	logic                  wn_s10 [9];
	logic signed [31:0]    det_s8;

	assign det_s8 = sa_s8[31:0];

	always_ff @(posedge clk) begin
		logic [WPW-1:0] mg;
		for (int i = 0; i < 3; i++) begin
			wp_s9[i]   <= p_s8[i] * det_s8;
			wp_s9[3+i] <= qt_s8[i] * det_s8;
			wp_s9[6+i] <= r_s8[i] * det_s8;
		end
		dg_s9 <= dg_s8;
		j0_s9 <= sa_s8[95:64];
		j1_s9 <= sa_s8[63:32];
		for (int i = 0; i < 9; i++) begin
			mg = wp_s9[i][WPW-1] ? (~wp_s9[i] + 1'b1) : wp_s9[i];
			wn_s10[i] <= wp_s9[i][WPW-1];
			wm_s10[i] <= MGW'(mg >> FRAC_BITS);
		end
		dg_s10 <= dg_s9;
		j0_s10 <= j0_s9;
		j1_s10 <= j1_s9;
	end

	// ---------------- s11: saturate and select by mode ----------------
	function automatic logic [31:0] sat_sm(input logic neg, input logic [MGW-1:0] m);
		logic [31:0] r;
		if (neg) begin
			r = (m > MGW'(64'h8000_0000)) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
		end else begin
			r = (m > MGW'(64'h7fff_ffff)) ? 32'h7fff_ffff : m[31:0];
		end
		return r;
	endfunction

	logic [31:0] fr_c [9];
	logic        dg_c;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			fr_c[i] = '0;
		end
		dg_c = 1'b0;
		unique case (mode_q)
			MODE_POINT: begin
				fr_c[0] = ONE;
			end
			MODE_LINE: begin
				fr_c[0] = j0_s10;
				fr_c[1] = j1_s10;
				fr_c[2] = j1_s10;
				// negating the most negative value saturates
				fr_c[3] = (j0_s10 == 32'sh8000_0000) ? 32'h7fff_ffff : -j0_s10;
			end
			MODE_SURFACE: begin
				dg_c = dg_s10;
				if (!dg_s10) begin
					for (int i = 0; i < 9; i++) begin
						fr_c[i] = sat_sm(wn_s10[i], wm_s10[i]);
					end
				end
			end
			default: begin
				dg_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		frame_0    <= fr_c[0];
		frame_1    <= fr_c[1];
		frame_2    <= fr_c[2];
		frame_3    <= fr_c[3];
		frame_4    <= fr_c[4];
		frame_5    <= fr_c[5];
		frame_6    <= fr_c[6];
		frame_7    <= fr_c[7];
		frame_8    <= fr_c[8];
		degenerate <= dg_c;
	end

endmodule

FILE: tb/tb_cell_orientation_frame_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cell_orientation_frame_top
// Self-checking bench for the cell orientation frame block. Jacobian
// transactions go in through a start/busy driver, and results come back
// through a done-strobe monitor. Each result is checked against a frame
// predicted in the bench. Configuration changes only while the block is idle.
// ----------------------------------------------------------------------------
module tb_cell_orientation_frame_top;
	import cof_pkg::*;

	localparam int      FRAC        = 16;
	localparam int      LATENCY     = 2 * FRAC + 91;
	localparam longint  CYCLE_LIMIT = 400000;
	localparam int      QUIET_TAIL  = 120;   // no random gaps among the last cells
	localparam logic [31:0] ONE     = 32'h0001_0000;

	typedef enum logic [1:0] {JOB_CELL, JOB_CFG, JOB_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t          kind;
		cfg_idx_t           idx;
		logic [31:0]        data;
		logic signed [31:0] jac [7];
	} job_t;

	typedef struct {
		logic signed [31:0] f [9];
		logic               degen;
	} frame_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_idx = '0;
	logic [31:0]        cfg_data = '0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] jac_in [7] = '{default: '0};
	logic               done;
	logic signed [31:0] frame_out [9];
	logic               degenerate;

	cell_orientation_frame_top #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.jac_0(jac_in[0]), .jac_1(jac_in[1]), .jac_2(jac_in[2]), .jac_3(jac_in[3]),
		.jac_4(jac_in[4]), .jac_5(jac_in[5]), .jac_det(jac_in[6]),
		.done(done),
		.frame_0(frame_out[0]), .frame_1(frame_out[1]), .frame_2(frame_out[2]),
		.frame_3(frame_out[3]), .frame_4(frame_out[4]), .frame_5(frame_out[5]),
		.frame_6(frame_out[6]), .frame_7(frame_out[7]), .frame_8(frame_out[8]),
		.degenerate(degenerate)
	);

	always #1 clk = ~clk;

	// bench copy of the configuration registers, reset values
	logic [1:0] mode_reg = MODE_SURFACE;
	longint     up_vec [3] = '{0, 0, 65536};

	job_t   pending [$];    // transactions and config writes not yet driven
	frame_t frames_due [$]; // predicted frames, oldest first
	bit     failed = 0;
	bit     taken = 0;      // the held start was accepted at the last edge
	int     gap_left = 0;
	int     cells_left = 0;
	longint cycles = 0;

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x) bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	// unit length in Q(FRAC); returns 0 for a zero vector
	function automatic bit normalize(input longint v [3], output longint u [3]);
		longint unsigned a [3];
		longint unsigned top, sum, len;
		int bl;
		top = 0;
		sum = 0;
		u = '{0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			a[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			if (a[i] > top) top = a[i];
		end
		if (top == 0) return 0;
		bl = 0;
		while (bl < 64 && (top >> bl) != 0) bl++;
		for (int i = 0; i < 3; i++) begin
			if (bl > NORM_BITS) a[i] >>= (bl - NORM_BITS);
			else a[i] <<= (NORM_BITS - bl);
			sum += a[i] * a[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			u[i] = longint'((a[i] << FRAC) / len);
			if (v[i] < 0) u[i] = -u[i];
		end
		return 1;
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3],
			output longint o [3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// divide by 2^FRAC, truncating toward zero
	function automatic longint descale(input longint v);
		return (v < 0) ? -((-v) >>> FRAC) : (v >>> FRAC);
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic frame_t cell_frame(input logic signed [31:0] j [7]);
		frame_t res;
		longint c0 [3], c1 [3], nrm [3], r [3], strike [3], p [3], q [3];
		longint w;
		res.f = '{default: '0};
		res.degen = 1'b0;
		w = j[6];
		if (mode_reg == MODE_POINT) begin
			res.f[0] = ONE;
		end else if (mode_reg == MODE_LINE) begin
			res.f[0] = j[0];
			res.f[1] = j[1];
			res.f[2] = j[1];
			res.f[3] = clip32(-longint'(j[0]));  // -(-2^31) saturates
		end else if (mode_reg == MODE_SURFACE) begin
			c0 = '{j[0], j[2], j[4]};
			c1 = '{j[1], j[3], j[5]};
			cross3(c0, c1, nrm);
			if (!normalize(nrm, r)) begin
				res.degen = 1'b1;
			end else begin
				cross3(up_vec, r, strike);
				if (!normalize(strike, p)) begin
					res.degen = 1'b1;
				end else begin
					cross3(r, p, q);
					for (int i = 0; i < 3; i++) begin
						res.f[i]     = clip32(descale(p[i] * w));
						res.f[3 + i] = clip32(descale(descale(q[i]) * w));
						res.f[6 + i] = clip32(descale(r[i] * w));
					end
				end
			end
		end
		// mode three leaves everything zero
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic logic signed [31:0] rnd_bits(input int nb);
		return $signed($urandom) >>> (32 - nb);
	endfunction

	function automatic logic signed [31:0] rnd_val();
		case ($urandom_range(0, 4))
			0: return $signed($urandom);
			1: return rnd_bits(8);
			default: return rnd_bits($urandom_range(12, 20));
		endcase
	endfunction

	task automatic add_cell(input logic signed [31:0] j0, j1, j2, j3, j4, j5, det);
		job_t jb;
		jb.kind = JOB_CELL;
		jb.idx = CFG_MODE;
		jb.data = '0;
		jb.jac = '{j0, j1, j2, j3, j4, j5, det};
		pending.push_back(jb);
	endtask

	task automatic add_cfg(input cfg_idx_t idx, input logic [31:0] data);
		job_t jb;
		jb.kind = JOB_CFG;
		jb.idx = idx;
		jb.data = data;
		jb.jac = '{default: '0};
		pending.push_back(jb);
	endtask

	task automatic add_setting(input logic [1:0] m, input logic [31:0] ux, uy, uz);
		add_cfg(CFG_MODE, {30'd0, m});
		add_cfg(CFG_UP_X, ux);
		add_cfg(CFG_UP_Y, uy);
		add_cfg(CFG_UP_Z, uz);
	endtask

	// one random surface cell; mostly well-formed, some degenerate shapes
	task automatic add_random_cell();
		logic signed [31:0] a0, a1, a2, b0, b1, b2, det;
		int k;
		a0 = rnd_val(); a1 = rnd_val(); a2 = rnd_val();
		b0 = rnd_val(); b1 = rnd_val(); b2 = rnd_val();
		det = ($urandom_range(0, 15) == 0) ? 32'sd0 : rnd_val();
		case ($urandom_range(0, 11))
			0: begin  // parallel columns, zero normal
				k = $urandom_range(0, 6) - 3;
				a0 = rnd_bits(14); a1 = rnd_bits(14); a2 = rnd_bits(14);
				b0 = a0 * k; b1 = a1 * k; b2 = a2 * k;
			end
			1: begin  // columns in the xy plane, normal along z
				a2 = 0; b2 = 0;
			end
			2: begin  // full-range words
				a0 = $urandom; a1 = $urandom; a2 = $urandom;
				b0 = $urandom; b1 = $urandom; b2 = $urandom; det = $urandom;
			end
			default: ;
		endcase
		add_cell(a0, b0, a1, b1, a2, b2, det);
	endtask

	task automatic add_drain();
		job_t jb;
		jb.kind = JOB_DRAIN;
		jb.idx = CFG_MODE;
		jb.data = '0;
		jb.jac = '{default: '0};
		pending.push_back(jb);
	endtask

	// ---------------------------------------------------------------- driver
	// Drives at the falling edge. A start that was not accepted is held.
	// Config writes wait until every predicted frame has come back.
	always @(negedge clk) begin
		logic               n_start, n_we;
		logic [1:0]         n_idx;
		logic [31:0]        n_data;
		logic signed [31:0] n_jac [7];
		job_t               jb;
		n_start = 1'b0;
		n_we = 1'b0;
		n_idx = cfg_idx;
		n_data = cfg_data;
		n_jac = jac_in;
		if (arst_n) begin
			if (start && !taken) begin
				n_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending.size() > 0) begin
				jb = pending[0];
				case (jb.kind)
					JOB_CELL: begin
						n_jac = jb.jac;
						n_start = 1'b1;
						void'(pending.pop_front());
						cells_left--;
						if (cells_left > QUIET_TAIL && $urandom_range(0, 5) == 0)
							gap_left = $urandom_range(1, 17);
					end
					JOB_CFG: begin
						if (frames_due.size() == 0) begin
							n_we = 1'b1;
							n_idx = jb.idx;
							n_data = jb.data;
							case (jb.idx)
								CFG_MODE: mode_reg = jb.data[1:0];
								CFG_UP_X: up_vec[0] = $signed(jb.data);
								CFG_UP_Y: up_vec[1] = $signed(jb.data);
								CFG_UP_Z: up_vec[2] = $signed(jb.data);
							endcase
							void'(pending.pop_front());
						end
					end
					JOB_DRAIN: begin
						if (frames_due.size() == 0) void'(pending.pop_front());
					end
					default: ;
				endcase
			end
		end
		start <= n_start;
		cfg_we <= n_we;
		cfg_idx <= n_idx;
		cfg_data <= n_data;
		jac_in <= n_jac;
	end

	// ---------------------------------------------------------------- monitor
	// Accepted transactions are predicted at the edge that takes them;
	// strobed results are checked against the oldest prediction.
	always @(posedge clk) begin
		frame_t want;
		if (arst_n) begin
			if (done) begin
				if (frames_due.size() == 0) begin
					$display("%0t: unexpected result, frame_0 %h degenerate %b",
						$time, frame_out[0], degenerate);
					failed = 1;
				end else begin
					want = frames_due.pop_front();
					if (want.f != frame_out || want.degen !== degenerate) begin
						$display("%0t: frame mismatch", $time);
						$display("  expected %h %h %h %h %h %h %h %h %h degen %b",
							want.f[0], want.f[1], want.f[2], want.f[3], want.f[4],
							want.f[5], want.f[6], want.f[7], want.f[8], want.degen);
						$display("  actual   %h %h %h %h %h %h %h %h %h degen %b",
							frame_out[0], frame_out[1], frame_out[2], frame_out[3],
							frame_out[4], frame_out[5], frame_out[6], frame_out[7],
							frame_out[8], degenerate);
						failed = 1;
					end
				end
			end
			if (start && !busy) frames_due.push_back(cell_frame(jac_in));
			taken <= start && !busy;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		// directed, reset setting: surface with up along z
		add_cell(0, 0, 0, 0, 0, 0, ONE);                           // zero normal
		add_cell(ONE, 0, 0, ONE, 0, 0, ONE);                       // normal along up
		add_cell(ONE, 0, 0, 0, 0, ONE, ONE);                       // vertical plane
		add_cell(ONE, 0, 0, 0, 0, ONE, 0);                         // zero weight
		add_cell(ONE, 32'sh4000, 32'sh8000, ONE, 32'sh2000, -32'sh3000, 32'sh0003_0000);
		add_cell(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		add_cell(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			1, -1, 32'sh8000_0000);
		add_cell(1, -1, -1, 1, 1, 1, 32'sh7fff_ffff);
		add_cell(-1, -1, -1, -1, -1, -1, -1);
		// line mode, including the negation of the most negative value
		add_setting(MODE_LINE, 0, 0, ONE);
		add_cell(32'sh8000_0000, 32'sh7fff_ffff, 5, 6, 7, 8, 9);
		add_cell(32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0, 0);
		add_cell(ONE, -ONE, -1, -1, -1, -1, -1);
		// point mode and the unused mode code
		add_setting(MODE_POINT, 0, 0, ONE);
		add_cell(-1, -1, -1, -1, -1, -1, -1);
		add_cell(0, 0, 0, 0, 0, 0, 0);
		add_setting(2'd3, 0, 0, ONE);
		add_cell(ONE, 2, 3, 4, 5, 6, ONE);
		add_cell(-1, -1, -1, -1, -1, -1, -1);
		// extreme up vectors
		add_setting(MODE_SURFACE, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
		add_cell(ONE, 32'sh4000, 32'sh8000, ONE, 32'sh2000, -32'sh3000, ONE);
		add_cell(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
		add_setting(MODE_SURFACE, 32'h8000_0000, 0, 0);
		add_cell(0, ONE, 0, 0, ONE, 0, ONE);                       // normal along y
		add_cell(ONE, 0, 0, ONE, 0, 0, 32'sh7fff_ffff);
		add_drain();   // hold off until the pipeline is empty

		// random phases, each under its own setting
		for (int ph = 0; ph < 11; ph++) begin
			logic [1:0]  m;
			logic [31:0] u [3];
			int          sel;
			sel = $urandom_range(0, 9);
			m = (sel < 6) ? MODE_SURFACE : (sel < 8) ? MODE_LINE :
				(sel == 8) ? MODE_POINT : 2'd3;
			case ($urandom_range(0, 3))
				0: u = '{$urandom, $urandom, $urandom};
				1: u = '{rnd_bits(18), rnd_bits(18), rnd_bits(18)};
				2: u = '{0, 0, rnd_bits(20)};
				default: u = '{rnd_bits(10), rnd_bits(10), $urandom};
			endcase
			if (ph == 0) m = MODE_SURFACE;
			add_setting(m, u[0], u[1], u[2]);
			for (int k = 0; k < 105; k++) add_random_cell();
		end
		foreach (pending[i]) if (pending[i].kind == JOB_CELL) cells_left++;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() > 0 || start || frames_due.size() > 0) @(posedge clk);
		repeat (LATENCY + 40) @(posedge clk);
		if (!failed) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
